@@ rtl/core/rsd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsd_pkg
// Shared types and constants of the run-length sprite row decoder.
// ----------------------------------------------------------------------------
package rsd_pkg;

    localparam int MAX_DIM_DEFAULT = 1024;

    localparam int BYTE_W   = 8;
    localparam int DIM_W    = 11;
    localparam int OFFSET_W = 10;
    localparam int COORD_W  = 11;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH    = 3'd0,
        REG_FRAME_HEIGHT   = 3'd1,
        REG_FRAME_OFFSET_X = 3'd2,
        REG_FRAME_OFFSET_Y = 3'd3,
        REG_IMAGE_WIDTH    = 3'd4,
        REG_IMAGE_HEIGHT   = 3'd5
    } cfg_reg_t;

    typedef enum logic [1:0] {
        PH_COUNT = 2'd0,
        PH_FLAG  = 2'd1,
        PH_DATA  = 2'd2
    } phase_t;

endpackage

@@ rtl/core/rsd_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsd_in_if
// Byte stream channel into the sprite decoder.
// ----------------------------------------------------------------------------
interface rsd_in_if
    import rsd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] sprite_byte;

    modport source (output valid, output sprite_byte, input ready);
    modport sink   (input valid, input sprite_byte, output ready);
endinterface

@@ rtl/core/rsd_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsd_out_if
// Pixel write / frame status channel out of the sprite decoder.
// ----------------------------------------------------------------------------
interface rsd_out_if
    import rsd_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               pixel_write;
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic [BYTE_W-1:0]  color_index;
    logic               frame_done;
    logic               frame_rejected;

    modport source (output valid, output pixel_write, output pixel_x, output pixel_y,
                    output color_index, output frame_done, output frame_rejected,
                    input ready);
    modport sink   (input valid, input pixel_write, input pixel_x, input pixel_y,
                    input color_index, input frame_done, input frame_rejected,
                    output ready);
endinterface

@@ rtl/core/rle_sprite_row_decoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle_sprite_row_decoder
// Parses a run-length encoded sprite frame, one byte per item, into pixel
// writes and a frame completion status.
// ----------------------------------------------------------------------------
// Usage:
//   sprite: byte stream in (count, flag, then index bytes per run).
//   pixel : zero or one result per byte: a pixel write, a frame completion,
//           or both on the last index byte of a frame.
//   cfg   : write-only register port (cfg_we, cfg_index, cfg_data); write it
//           only while the decoder is idle.
// Throughput is one byte per cycle while the receiver does not stall: the
// phase update and the column add are done in the cycle the byte is accepted,
// and the result is registered in the output register.
// Bytes that produce no result are consumed without touching the output.
// While the receiver stalls, the pending result holds in the output register;
// a new byte is still taken in the cycle that result is taken.
// Reset clears all registers, puts the parser at the count byte and empties
// the output register.
// While frame_width or frame_height is zero every byte is dropped.
// ----------------------------------------------------------------------------
module rle_sprite_row_decoder
    import rsd_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEFAULT
)(
    input  logic                 clk,
    input  logic                 rst_n,
    rsd_in_if.sink               sprite,
    rsd_out_if.source            pixel,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data
);

    localparam int             LIM_W   = $clog2(MAX_DIM + 1) + 1;
    localparam logic [LIM_W-1:0] MaxDimC = LIM_W'(MAX_DIM);

    // configuration
    logic [DIM_W-1:0]    frame_width_reg, frame_height_reg;
    logic [OFFSET_W-1:0] frame_offset_x_reg, frame_offset_y_reg;
    logic [DIM_W-1:0]    image_width_reg, image_height_reg;

    // parser state
    phase_t              phase_reg, phase_next;
    logic [BYTE_W-1:0]   run_length_reg, run_length_next;
    logic [BYTE_W-1:0]   run_remaining_reg, run_remaining_next;
    logic [DIM_W-1:0]    column_reg, column_next;
    logic [DIM_W-1:0]    row_reg, row_next;

    // result register
    logic                out_valid_reg, out_valid_next;
    logic                pix_write_reg, pix_write_next;
    logic [COORD_W-1:0]  pix_x_reg, pix_x_next;
    logic [COORD_W-1:0]  pix_y_reg, pix_y_next;
    logic [BYTE_W-1:0]   color_reg, color_next;
    logic                done_reg, done_next;
    logic                rejected_reg, rejected_next;

    logic                accept;
    logic                empty_frame;
    logic                oversized;
    logic [DIM_W:0]      adv_col;
    logic                row_end;
    logic                last_row;
    logic                do_advance;
    logic [BYTE_W-1:0]   rem_dec;
    logic [DIM_W:0]      data_col;
    logic                pix;
    logic                done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg    <= '0;
            frame_height_reg   <= '0;
            frame_offset_x_reg <= '0;
            frame_offset_y_reg <= '0;
            image_width_reg    <= '0;
            image_height_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:    frame_width_reg    <= cfg_data;
                REG_FRAME_HEIGHT:   frame_height_reg   <= cfg_data;
                REG_FRAME_OFFSET_X: frame_offset_x_reg <= cfg_data[OFFSET_W-1:0];
                REG_FRAME_OFFSET_Y: frame_offset_y_reg <= cfg_data[OFFSET_W-1:0];
                REG_IMAGE_WIDTH:    image_width_reg    <= cfg_data;
                REG_IMAGE_HEIGHT:   image_height_reg   <= cfg_data;
                default:            ;
            endcase
        end
    end

    assign sprite.ready = !out_valid_reg || pixel.ready;
    assign accept       = sprite.valid && sprite.ready;

    assign empty_frame = (frame_width_reg == '0) || (frame_height_reg == '0);
    assign oversized   = (frame_width_reg > image_width_reg)
                      || (frame_height_reg > image_height_reg)
                      || (LIM_W'(frame_width_reg) > MaxDimC)
                      || (LIM_W'(frame_height_reg) > MaxDimC);

    // column and row advance at the end of a run
    assign adv_col  = {1'b0, column_reg} + (DIM_W+1)'(run_length_reg);
    assign row_end  = adv_col >= {1'b0, frame_width_reg};
    assign last_row = ({1'b0, row_reg} + 1'b1) >= {1'b0, frame_height_reg};
    assign rem_dec  = run_remaining_reg - 1'b1;
    assign data_col = {1'b0, column_reg}
                    + (DIM_W+1)'(run_length_reg - run_remaining_reg);

    // next state
    always_comb
    begin
        phase_next         = phase_reg;
        run_length_next    = run_length_reg;
        run_remaining_next = run_remaining_reg;
        do_advance         = 1'b0;
        if (accept && !empty_frame)
        begin
            unique case (phase_reg)
                PH_FLAG:
                begin
                    if (sprite.sprite_byte != '0 && run_length_reg != '0)
                    begin
                        run_remaining_next = run_length_reg;
                        phase_next         = PH_DATA;
                    end
                    else
                    begin
                        phase_next = PH_COUNT;
                        do_advance = 1'b1;
                    end
                end
                PH_DATA:
                begin
                    run_remaining_next = rem_dec;
                    if (rem_dec == '0)
                    begin
                        phase_next = PH_COUNT;
                        do_advance = 1'b1;
                    end
                end
                default:
                begin
                    run_length_next = sprite.sprite_byte;
                    phase_next      = PH_FLAG;
                end
            endcase
        end

        column_next = column_reg;
        row_next    = row_reg;
        done        = 1'b0;
        if (do_advance)
        begin
            if (!row_end)
            begin
                column_next = adv_col[DIM_W-1:0];
            end
            else
            begin
                column_next = '0;
                if (last_row)
                begin
                    row_next = '0;
                    done     = 1'b1;
                end
                else
                begin
                    row_next = row_reg + 1'b1;
                end
            end
        end
    end

    // result
    always_comb
    begin
        pix            = accept && !empty_frame && (phase_reg == PH_DATA) && !oversized;
        out_valid_next = out_valid_reg && !pixel.ready;
        pix_write_next = pix_write_reg;
        pix_x_next     = pix_x_reg;
        pix_y_next     = pix_y_reg;
        color_next     = color_reg;
        done_next      = done_reg;
        rejected_next  = rejected_reg;
        if (pix || done)
        begin
            out_valid_next = 1'b1;
            pix_write_next = pix;
            pix_x_next     = pix ? (COORD_W'(frame_offset_x_reg) + data_col[COORD_W-1:0])
                                 : '0;
            pix_y_next     = pix ? (COORD_W'(frame_offset_y_reg) + row_reg) : '0;
            color_next     = pix ? sprite.sprite_byte : '0;
            done_next      = done;
            rejected_next  = done && oversized;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_COUNT;
            run_length_reg    <= '0;
            run_remaining_reg <= '0;
            column_reg        <= '0;
            row_reg           <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            phase_reg         <= phase_next;
            run_length_reg    <= run_length_next;
            run_remaining_reg <= run_remaining_next;
            column_reg        <= column_next;
            row_reg           <= row_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_write_reg <= 1'b0;
            pix_x_reg     <= '0;
            pix_y_reg     <= '0;
            color_reg     <= '0;
            done_reg      <= 1'b0;
            rejected_reg  <= 1'b0;
        end
        else
        begin
            pix_write_reg <= pix_write_next;
            pix_x_reg     <= pix_x_next;
            pix_y_reg     <= pix_y_next;
            color_reg     <= color_next;
            done_reg      <= done_next;
            rejected_reg  <= rejected_next;
        end
    end

    assign pixel.valid          = out_valid_reg;
    assign pixel.pixel_write    = pix_write_reg;
    assign pixel.pixel_x        = pix_x_reg;
    assign pixel.pixel_y        = pix_y_reg;
    assign pixel.color_index    = color_reg;
    assign pixel.frame_done     = done_reg;
    assign pixel.frame_rejected = rejected_reg;

endmodule

@@ tb/rle_sprite_row_decoder_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle_sprite_row_decoder_test
// Self-checking bench for the run-length sprite row decoder. A short table of
// hand-written streams and register writes comes first, followed by random
// frames made of well-formed runs with some stray bytes mixed in. The bench
// decodes every accepted byte in its own model, queues the pixel writes and
// frame status it predicts, and compares each result the block returns.
// ----------------------------------------------------------------------------
module rle_sprite_row_decoder_test;

    import rsd_pkg::*;

    localparam int MAX_DIM      = MAX_DIM_DEFAULT;
    localparam int RANDOM_BYTES = 1800;
    localparam int PHASE_BYTES  = 200;
    localparam int STALL_LIMIT  = 4000;

    typedef struct packed {
        logic               pix;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [BYTE_W-1:0]  ci;
        logic               done;
        logic               rej;
    } pixel_result_t;

    typedef enum logic {ROW_BYTE, ROW_REG} row_kind_t;

    typedef struct packed {
        row_kind_t          kind;
        cfg_reg_t           reg_idx;
        logic [DIM_W-1:0]   value;
        logic               typed;
        logic               yields;
        pixel_result_t      res;
    } dir_row_t;

    localparam pixel_result_t NO_RESULT = '0;

    // Frame 4x2 placed at the far corner, then a different stream with the
    // image made narrower than the frame.
    localparam int DIR_ROWS = 32;
    localparam dir_row_t DIRECTED [DIR_ROWS] = '{
        // nothing configured yet: bytes are dropped
        '{ROW_BYTE, REG_FRAME_WIDTH,    11'h0FF, 1'b1, 1'b0, NO_RESULT},
        '{ROW_BYTE, REG_FRAME_WIDTH,    11'h000, 1'b1, 1'b0, NO_RESULT},
        '{ROW_REG,  REG_FRAME_WIDTH,    11'd4,    1'b0, 1'b0, NO_RESULT},
        '{ROW_REG,  REG_FRAME_HEIGHT,   11'd2,    1'b0, 1'b0, NO_RESULT},
        '{ROW_REG,  REG_FRAME_OFFSET_X, 11'd1023, 1'b0, 1'b0, NO_RESULT},
        '{ROW_REG,  REG_FRAME_OFFSET_Y, 11'd1023, 1'b0, 1'b0, NO_RESULT},
        '{ROW_REG,  REG_IMAGE_WIDTH,    11'd1024, 1'b0, 1'b0, NO_RESULT},
        '{ROW_REG,  REG_IMAGE_HEIGHT,   11'd1024, 1'b0, 1'b0, NO_RESULT},
        // row 0: two pixels, a zero-length run, then a skip across the row end
        '{ROW_BYTE, REG_FRAME_WIDTH,    11'h002, 1'b0, 1'b0, NO_RESULT},
        '{ROW_BYTE, REG_FRAME_WIDTH,    11'h001, 1'b0, 1'b0, NO_RESULT},
        '{ROW_BYTE, REG_FRAME_WIDTH,    11'h000, 1'b1, 1'b1,
            '{1'b1, 11'd1023, 11'd1023, 8'h00, 1'b0, 1'b0}},
        '{ROW_BYTE, REG_FRAME_WIDTH,    11'h0FF, 1'b1, 1'b1,
            '{1'b1, 11'd1024, 11'd1023, 8'hFF, 1'b0, 1'b0}},
        '{ROW_BYTE, REG_FRAME_WIDTH,    11'h000, 1'b0, 1'b0, NO_RESULT},
        '{ROW_BYTE, REG_FRAME_WIDTH,    11'h005, 1'b1, 1'b0, NO_RESULT},
        '{ROW_BYTE, REG_FRAME_WIDTH,    11'h003, 1'b0, 1'b0, NO_RESULT},
        '{ROW_BYTE, REG_FRAME_WIDTH,    11'h000, 1'b1, 1'b0, NO_RESULT},
        // row 1: a five-pixel run past the row end closes the frame
        '{ROW_BYTE, REG_FRAME_WIDTH,    11'h005, 1'b0, 1'b0, NO_RESULT},
        '{ROW_BYTE, REG_FRAME_WIDTH,    11'h009, 1'b0, 1'b0, NO_RESULT},
        '{ROW_BYTE, REG_FRAME_WIDTH,    11'h00A, 1'b0, 1'b0, NO_RESULT},
        '{ROW_BYTE, REG_FRAME_WIDTH,    11'h00B, 1'b0, 1'b0, NO_RESULT},
        '{ROW_BYTE, REG_FRAME_WIDTH,    11'h00C, 1'b0, 1'b0, NO_RESULT},
        '{ROW_BYTE, REG_FRAME_WIDTH,    11'h00D, 1'b0, 1'b0, NO_RESULT},
        '{ROW_BYTE, REG_FRAME_WIDTH,    11'h00E, 1'b1, 1'b1,
            '{1'b1, 11'd1027, 11'd1024, 8'h0E, 1'b1, 1'b0}},
        // oversized: parsed, nothing written, rejected on completion
        '{ROW_REG,  REG_IMAGE_WIDTH,    11'd3,    1'b0, 1'b0, NO_RESULT},
        '{ROW_BYTE, REG_FRAME_WIDTH,    11'h0FF, 1'b0, 1'b0, NO_RESULT},
        '{ROW_BYTE, REG_FRAME_WIDTH,    11'h000, 1'b1, 1'b0, NO_RESULT},
        '{ROW_BYTE, REG_FRAME_WIDTH,    11'h004, 1'b0, 1'b0, NO_RESULT},
        '{ROW_BYTE, REG_FRAME_WIDTH,    11'h007, 1'b0, 1'b0, NO_RESULT},
        '{ROW_BYTE, REG_FRAME_WIDTH,    11'h011, 1'b1, 1'b0, NO_RESULT},
        '{ROW_BYTE, REG_FRAME_WIDTH,    11'h022, 1'b1, 1'b0, NO_RESULT},
        '{ROW_BYTE, REG_FRAME_WIDTH,    11'h033, 1'b1, 1'b0, NO_RESULT},
        '{ROW_BYTE, REG_FRAME_WIDTH,    11'h044, 1'b1, 1'b1,
            '{1'b0, 11'd0, 11'd0, 8'h00, 1'b1, 1'b1}}
    };

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DIM_W-1:0]     cfg_data;

    rsd_in_if  sprite_ch ();
    rsd_out_if pixel_ch ();

    rle_sprite_row_decoder u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sprite    (sprite_ch),
        .pixel     (pixel_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    // Decoder copy: registers and parser state
    logic [DIM_W-1:0]    frm_w = '0;
    logic [DIM_W-1:0]    frm_h = '0;
    logic [OFFSET_W-1:0] org_x = '0;
    logic [OFFSET_W-1:0] org_y = '0;
    logic [DIM_W-1:0]    img_w = '0;
    logic [DIM_W-1:0]    img_h = '0;
    phase_t              parse_phase = PH_COUNT;
    logic [BYTE_W-1:0]   run_len = '0;
    logic [BYTE_W-1:0]   run_left = '0;
    logic [DIM_W-1:0]    col_pos = '0;
    logic [DIM_W-1:0]    row_pos = '0;

    pixel_result_t pixel_backlog [$];

    int sender_idle_pct = 0;
    int sink_stall_pct  = 0;
    int bytes_decoded   = 0;
    int bytes_ignored   = 0;
    int reg_writes      = 0;
    int writes_seen     = 0;
    int frames_seen     = 0;
    int rejects_seen    = 0;
    int errors          = 0;
    int quiet_cycles    = 0;

    // Move the column by n; returns 1 when this closes the frame.
    function automatic bit next_column(input logic [BYTE_W-1:0] n);
        int nxt;
        nxt = int'(col_pos) + int'(n);
        if (nxt < int'(frm_w))
        begin
            col_pos = DIM_W'(nxt);
            return 1'b0;
        end
        col_pos = '0;
        if (int'(row_pos) + 1 >= int'(frm_h))
        begin
            row_pos = '0;
            return 1'b1;
        end
        row_pos = row_pos + 1'b1;
        return 1'b0;
    endfunction

    task automatic decode_byte(input logic [BYTE_W-1:0] b, output bit yields,
                               output pixel_result_t res);
        bit rej;
        bit done;
        int col;
        res    = NO_RESULT;
        yields = 1'b0;
        done   = 1'b0;
        if (frm_w == 0 || frm_h == 0)
            return;
        rej = (frm_w > img_w) || (frm_h > img_h) || (frm_w > MAX_DIM) || (frm_h > MAX_DIM);
        case (parse_phase)
            PH_FLAG:
            begin
                if (b != 0 && run_len != 0)
                begin
                    run_left    = run_len;
                    parse_phase = PH_DATA;
                end
                else
                begin
                    parse_phase = PH_COUNT;
                    done = next_column(run_len);
                end
            end
            PH_DATA:
            begin
                col = int'(col_pos) + int'(run_len) - int'(run_left);
                if (!rej)
                begin
                    res.pix = 1'b1;
                    res.x   = COORD_W'(int'(org_x) + col);
                    res.y   = COORD_W'(int'(org_y) + int'(row_pos));
                    res.ci  = b;
                end
                run_left = run_left - 1'b1;
                if (run_left == 0)
                begin
                    parse_phase = PH_COUNT;
                    done = next_column(run_len);
                end
            end
            default:
            begin
                run_len     = b;
                parse_phase = PH_FLAG;
            end
        endcase
        res.done = done;
        res.rej  = done && rej;
        yields   = res.pix || done;
    endtask

    // Drop valid, let the block drain, then write one register.
    task automatic write_reg(input cfg_reg_t idx, input logic [DIM_W-1:0] value);
        sprite_ch.valid <= 1'b0;
        while (pixel_backlog.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_FRAME_WIDTH:    frm_w = value;
            REG_FRAME_HEIGHT:   frm_h = value;
            REG_FRAME_OFFSET_X: org_x = value[OFFSET_W-1:0];
            REG_FRAME_OFFSET_Y: org_y = value[OFFSET_W-1:0];
            REG_IMAGE_WIDTH:    img_w = value;
            REG_IMAGE_HEIGHT:   img_h = value;
            default: ;
        endcase
        reg_writes++;
    endtask

    // Offer one byte; a typed row overrides what the model predicts.
    task automatic send_byte(input logic [BYTE_W-1:0] b, input bit typed,
                             input bit typed_yields, input pixel_result_t typed_res);
        bit            yields;
        pixel_result_t res;
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            sprite_ch.valid <= 1'b0;
            @(posedge clk);
        end
        sprite_ch.valid       <= 1'b1;
        sprite_ch.sprite_byte <= b;
        @(posedge clk);
        while (sprite_ch.ready !== 1'b1)
            @(posedge clk);
        if (frm_w == 0 || frm_h == 0)
            bytes_ignored++;
        else
            bytes_decoded++;
        decode_byte(b, yields, res);
        if (typed)
        begin
            yields = typed_yields;
            res    = typed_res;
        end
        if (yields)
            pixel_backlog.push_back(res);
    endtask

    // One run: count, flag and, for a nonzero flag, its index bytes.
    task automatic send_run();
        logic [BYTE_W-1:0] cnt;
        logic [BYTE_W-1:0] flag;
        int                lim;
        flag = ($urandom_range(0, 2) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
        if (flag == 8'h00)
            lim = (frm_w > 254) ? 255 : int'(frm_w) + 1;
        else
            lim = (frm_w > 64) ? 48 : ((frm_w > 12) ? 14 : int'(frm_w) + 2);
        case ($urandom_range(0, 31))
            0, 1:    cnt = 8'h00;
            2:       cnt = 8'hFF;
            default: cnt = 8'($urandom_range(1, lim));
        endcase
        send_byte(cnt, 1'b0, 1'b0, NO_RESULT);
        send_byte(flag, 1'b0, 1'b0, NO_RESULT);
        if (flag != 0)
            repeat (cnt) send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0, NO_RESULT);
    endtask

    // Result side: random stalls, compare against the oldest prediction
    initial
    begin
        pixel_result_t got;
        pixel_result_t want;
        pixel_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && pixel_ch.valid === 1'b1 && pixel_ch.ready === 1'b1)
            begin
                got = '{pixel_ch.pixel_write, pixel_ch.pixel_x, pixel_ch.pixel_y,
                        pixel_ch.color_index, pixel_ch.frame_done, pixel_ch.frame_rejected};
                writes_seen  += got.pix;
                frames_seen  += got.done;
                rejects_seen += got.rej;
                if (pixel_backlog.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected item write=%0b x=%0d y=%0d idx=%02h done=%0b rej=%0b",
                             $time, got.pix, got.x, got.y, got.ci, got.done, got.rej);
                end
                else
                begin
                    want = pixel_backlog.pop_front();
                    if (got !== want)
                    begin
                        errors++;
                        $display("%0t: mismatch expected write=%0b x=%0d y=%0d idx=%02h done=%0b rej=%0b",
                                 $time, want.pix, want.x, want.y, want.ci, want.done, want.rej);
                        $display("%0t:          actual   write=%0b x=%0d y=%0d idx=%02h done=%0b rej=%0b",
                                 $time, got.pix, got.x, got.y, got.ci, got.done, got.rej);
                    end
                end
            end
            pixel_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    // Watchdog: end the run if no item moves for too long
    always @(posedge clk)
    begin
        if ((sprite_ch.valid === 1'b1 && sprite_ch.ready === 1'b1) ||
            (pixel_ch.valid === 1'b1 && pixel_ch.ready === 1'b1))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no item moved for %0d cycles, %0d results still pending",
                     $time, STALL_LIMIT, pixel_backlog.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        int target;
        int phase_start;
        int p;
        logic [DIM_W-1:0]    fw, fh, iw, ih;
        logic [OFFSET_W-1:0] ox, oy;
        rst_n                 <= 1'b0;
        sprite_ch.valid       <= 1'b0;
        sprite_ch.sprite_byte <= '0;
        cfg_we                <= 1'b0;
        cfg_index             <= REG_FRAME_WIDTH;
        cfg_data              <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED[i])
        begin
            if (DIRECTED[i].kind == ROW_REG)
                write_reg(DIRECTED[i].reg_idx, DIRECTED[i].value);
            else
                send_byte(DIRECTED[i].value[BYTE_W-1:0], DIRECTED[i].typed,
                          DIRECTED[i].yields, DIRECTED[i].res);
        end

        target = bytes_decoded + RANDOM_BYTES;
        p = 0;
        while (bytes_decoded < target)
        begin
            ox = ($urandom_range(0, 3) == 0) ? '0 : OFFSET_W'($urandom_range(0, 1023));
            oy = ($urandom_range(0, 3) == 0) ? '0 : OFFSET_W'($urandom_range(0, 1023));
            fw = DIM_W'($urandom_range(1, 16));
            fh = DIM_W'($urandom_range(1, 6));
            iw = ($urandom_range(0, 3) == 0) ? fw : DIM_W'($urandom_range(fw, 1024));
            ih = ($urandom_range(0, 3) == 0) ? fh : DIM_W'($urandom_range(fh, 1024));
            case (p % 8)
                0:
                begin
                    // widest legal frame at the far corner: columns wrap
                    fw = 11'd1024;
                    fh = DIM_W'($urandom_range(1, 2));
                    ox = 10'd1023;
                    oy = 10'd1023;
                    iw = 11'd1024;
                    ih = 11'd1024;
                end
                1:
                begin
                    if ($urandom_range(0, 1) == 0)
                        fw = '0;
                    else
                        fh = '0;
                end
                2:
                begin
                    // beyond the size limit even though the image is large
                    iw = 11'd2047;
                    ih = 11'd2047;
                    if ($urandom_range(0, 1) == 0)
                    begin
                        fw = DIM_W'($urandom_range(MAX_DIM + 1, 2047));
                        fh = 11'd1;
                    end
                    else
                    begin
                        fw = DIM_W'($urandom_range(1, 3));
                        fh = DIM_W'($urandom_range(MAX_DIM + 1, 2047));
                    end
                end
                3:
                begin
                    if ($urandom_range(0, 1) == 0)
                        iw = fw - 1'b1;
                    else
                        ih = fh - 1'b1;
                end
                default: ;
            endcase
            write_reg(REG_FRAME_WIDTH, fw);
            write_reg(REG_FRAME_HEIGHT, fh);
            write_reg(REG_FRAME_OFFSET_X, DIM_W'(ox));
            write_reg(REG_FRAME_OFFSET_Y, DIM_W'(oy));
            write_reg(REG_IMAGE_WIDTH, iw);
            write_reg(REG_IMAGE_HEIGHT, ih);

            case (p % 4)
                0:       begin sender_idle_pct = 0;  sink_stall_pct = 0;  end
                1:       begin sender_idle_pct = 62; sink_stall_pct = 0;  end
                2:       begin sender_idle_pct = 0;  sink_stall_pct = 62; end
                default: begin sender_idle_pct = 6;  sink_stall_pct = 6;  end
            endcase

            phase_start = bytes_decoded;
            if (fw == 0 || fh == 0)
                repeat (24) send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0, NO_RESULT);
            else
                while (bytes_decoded - phase_start < PHASE_BYTES && bytes_decoded < target)
                begin
                    // a stray byte now and then shifts the run framing
                    if ($urandom_range(0, 9) == 0)
                        send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0, NO_RESULT);
                    else
                        send_run();
                end
            p++;
        end

        sprite_ch.valid <= 1'b0;
        while (pixel_backlog.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Decoded %0d bytes (%0d dropped while unconfigured) across %0d register writes",
                 bytes_decoded, bytes_ignored, reg_writes);
        $display("Checked %0d pixel writes and %0d finished frames, %0d of them rejected",
                 writes_seen, frames_seen, rejects_seen);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
